/* src/sidta_pkg.sv */
package sidta_pkg;

  localparam int CHAR_W = 6;
  localparam int LEN_W  = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_HOLD
  } state_t;

  // decimal digits of 2^(w-1); 30103/100000 is log10(2) rounded up
  function automatic int num_digits(input int w);
    num_digits = (((w - 1) * 30103) / 100000) + 1;
  endfunction

endpackage

/* src/sidta_dabble.sv */
module sidta_dabble #(
  parameter int W    = 32,
  parameter int NDIG = 10,
  parameter int SW   = 4,
  parameter int IW   = 4,
  parameter int CW   = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [W-1:0]        value,
  output logic [4*NDIG-1:0]   bcd,
  output logic [SW-1:0]       sig,
  output logic                neg,
  output logic                done
);
  import sidta_pkg::*;

  logic [W-1:0]      mag;
  logic [CW-1:0]     cnt;
  logic              run;
  logic [4*NDIG-1:0] adj;
  logic [4*NDIG-1:0] shifted;
  logic [SW-1:0]     sig_next;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign shifted = {adj[4*NDIG-2:0], mag[W-1]};

  // only the digit just above the significant ones can turn nonzero
  always_comb begin
    sig_next = sig;
    if (sig < SW'(NDIG)) begin
      if (shifted[4*sig[IW-1:0] +: 4] != 4'd0) begin
        sig_next = sig + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= value[W-1];
      mag <= value[W-1] ? (~value + {{(W-1){1'b0}}, 1'b1}) : value;
      bcd <= '0;
      sig <= '0;
    end else if (run) begin
      mag <= {mag[W-2:0], 1'b0};
      bcd <= shifted;
      sig <= sig_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("dabble done while still shifting");
  assert property (@(posedge clk) disable iff (rst) run |-> (cnt < CW'(W - 1)) || (cnt == CW'(W - 1)))
    else $error("dabble shift count out of range");

endmodule

/* src/sidta_emit.sv */
module sidta_emit #(
  parameter int NDIG = 10,
  parameter int SW   = 4,
  parameter int IW   = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [4*NDIG-1:0]              bcd,
  input  logic [SW-1:0]                  sig,
  input  logic                           neg,
  output logic                           busy,
  output logic                           text_valid,
  input  logic                           text_ready,
  output logic [sidta_pkg::CHAR_W-1:0]   text_char,
  output logic                           last_char,
  output logic [sidta_pkg::LEN_W-1:0]    text_length
);
  import sidta_pkg::*;

  localparam int LW = (SW + 1 > LEN_W) ? SW + 1 : LEN_W;

  logic [4*NDIG-1:0] dig;
  logic [IW-1:0]     pos;
  logic [LW-1:0]     len;
  logic              active;
  logic              sign_pend;
  logic [SW-1:0]     nd;
  logic              adv;

  assign nd   = (sig == '0) ? SW'(1) : sig;
  assign busy = active || text_valid;
  assign adv  = active && (!text_valid || text_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      sign_pend  <= 1'b0;
      text_valid <= 1'b0;
    end else begin
      if (start) begin
        active    <= 1'b1;
        sign_pend <= neg;
      end else if (adv) begin
        text_valid <= 1'b1;
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else if (pos == '0) begin
          active <= 1'b0;
        end
      end else if (text_ready) begin
        text_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dig <= bcd;
      pos <= IW'(nd - SW'(1));
      len <= LW'(nd) + LW'(neg);
    end else if (adv) begin
      text_length <= len[LEN_W-1:0];
      if (sign_pend) begin
        text_char <= CHAR_MINUS;
        last_char <= 1'b0;
      end else begin
        text_char <= CHAR_ZERO + {2'b00, dig[4*pos +: 4]};
        last_char <= (pos == '0);
        if (pos != '0) begin
          pos <= pos - IW'(1);
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("emitter restarted while busy");
  assert property (@(posedge clk) disable iff (rst) (text_valid && last_char) |-> !active)
    else $error("last character shown with digits still pending");
  assert property (@(posedge clk) disable iff (rst) sign_pend |-> active)
    else $error("sign pending on an idle emitter");

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// channel | signals                                  | accepted when
// input   | value_valid, value_ready, value          | value_valid && value_ready
// output  | text_valid, text_ready, text_char,       | text_valid && text_ready
//         |   last_char, text_length                 |
//
// An item goes through a load (sign and magnitude), a double-dabble shift per
// magnitude bit and a hand-off to the emitter. Characters leave at one per
// cycle while text_ready is high, from an output register, while the next
// item is already shifting; a new item waits if the emitter still holds text.
// rst is synchronous and clears only control state.
// A stalled output holds its character; the converter then holds its digits.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            value_valid,
  output logic                            value_ready,
  input  logic signed [VALUE_WIDTH-1:0]   value,
  output logic                            text_valid,
  input  logic                            text_ready,
  output logic [sidta_pkg::CHAR_W-1:0]    text_char,
  output logic                            last_char,
  output logic [sidta_pkg::LEN_W-1:0]     text_length
);
  import sidta_pkg::*;

  localparam int NDIG = num_digits(VALUE_WIDTH);
  localparam int SW   = $clog2(NDIG + 1);
  localparam int IW   = $clog2(NDIG);
  localparam int CW   = $clog2(VALUE_WIDTH);

  state_t            state;
  state_t            state_next;
  logic              load;
  logic              start;
  logic              done;
  logic              busy;
  logic              neg;
  logic [SW-1:0]     sig;
  logic [4*NDIG-1:0] bcd;

  sidta_dabble #(
    .W    (VALUE_WIDTH),
    .NDIG (NDIG),
    .SW   (SW),
    .IW   (IW),
    .CW   (CW)
  ) u_dabble (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .value (value),
    .bcd   (bcd),
    .sig   (sig),
    .neg   (neg),
    .done  (done)
  );

  sidta_emit #(
    .NDIG (NDIG),
    .SW   (SW),
    .IW   (IW)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .bcd         (bcd),
    .sig         (sig),
    .neg         (neg),
    .busy        (busy),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .text_char   (text_char),
    .last_char   (last_char),
    .text_length (text_length)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (value_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (done) state_next = busy ? ST_HOLD : ST_IDLE;
      end
      ST_HOLD: begin
        if (!busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    value_ready = 1'b0;
    start       = 1'b0;
    case (state)
      ST_IDLE: value_ready = 1'b1;
      ST_CONV: start = done && !busy;
      ST_HOLD: start = !busy;
      default: value_ready = 1'b0;
    endcase
  end

  assign load = value_valid && value_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> state == ST_CONV)
    else $error("conversion finished outside the converting state");

endmodule
